/* design/aoc_pkg.sv */
// shared types and codes for the box overlap contact block
package aoc_pkg;

	typedef logic [1:0] axis_t;

	localparam axis_t AXIS_X    = 2'd0;
	localparam axis_t AXIS_Y    = 2'd1;
	localparam axis_t AXIS_Z    = 2'd2;
	localparam axis_t AXIS_NONE = 2'd3;

	typedef struct packed {
		logic miss;
		logic neg;
	} aoc_flags_t;

endpackage

/* design/aabb_overlap_contact.sv */
// top level: box overlap test with least-penetration axis and contact point
// a z item crosses the input register, then the result register, to its result on m_
// one item per cycle unless a z item waits on the result slot; a box pair is 3 items
// the per-axis adds, compares and midpoint sit between the input and result registers
// reset (arst_n low) empties both registers and clears the best-axis state to zero
module aabb_overlap_contact #(
	parameter int COORD_WIDTH = 32,
	localparam int IN_DATA_W  = ((6 * COORD_WIDTH - 2 + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((4 * COORD_WIDTH + 2 + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input transfers, one axis per transfer in order x, y, z
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// a_position, a_offset, a_half_size, b_position, b_offset, b_half_size
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// axis
	input  aoc_pkg::axis_t        s_tuser,
	// result transfers, one per z item
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// depth, normal_axis, normal_negative, contact_x, contact_y, contact_z
	output logic [OUT_DATA_W-1:0] m_tdata,
	// hit
	output logic [0:0]            m_tuser
);
	import aoc_pkg::*;

	localparam int W = COORD_WIDTH;

	// input register stage
	logic                valid_s1;
	axis_t               axis_s1;
	logic signed [W-1:0] a_position_s1, a_offset_s1, b_position_s1, b_offset_s1;
	logic        [W-2:0] a_half_size_s1, b_half_size_s1;

	// per-axis evaluation
	logic        [W-1:0] ax_depth;
	logic signed [W-1:0] ax_contact;
	aoc_flags_t          ax_flags;

	// fold outputs
	logic                emit, hit, res_negative;
	logic        [W-2:0] res_depth;
	axis_t               res_axis;
	logic signed [W-1:0] res_contact_x, res_contact_y, res_contact_z;

	// result register
	logic                out_valid_q;
	logic                hit_q;
	logic        [W-2:0] depth_q;
	axis_t               normal_axis_q;
	logic                normal_negative_q;
	logic signed [W-1:0] contact_x_q, contact_y_q, contact_z_q;

	logic out_free, consume_s1;

	// result slot frees when empty or being taken this cycle
	assign out_free = !out_valid_q || m_tready;
	// only a z item needs the result slot; others always drain
	assign consume_s1 = valid_s1 && ((axis_s1 != AXIS_Z) || out_free);
	assign s_tready = !valid_s1 || consume_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload of the input stage, field slices from the lowest bit up
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			axis_s1         <= s_tuser;
			a_position_s1   <= s_tdata[W-1:0];
			a_offset_s1     <= s_tdata[2*W-1:W];
			a_half_size_s1  <= s_tdata[3*W-2:2*W];
			b_position_s1   <= s_tdata[4*W-2:3*W-1];
			b_offset_s1     <= s_tdata[5*W-2:4*W-1];
			b_half_size_s1  <= s_tdata[6*W-3:5*W-1];
		end
	end

	aoc_axis_eval #(.W(W)) u_axis_eval (
		.a_position  (a_position_s1),
		.a_offset    (a_offset_s1),
		.a_half_size (a_half_size_s1),
		.b_position  (b_position_s1),
		.b_offset    (b_offset_s1),
		.b_half_size (b_half_size_s1),
		.depth       (ax_depth),
		.contact     (ax_contact),
		.flags       (ax_flags)
	);

	// state folds in when the input stage drains an x, y or z item
	aoc_fold #(.W(W)) u_fold (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (consume_s1),
		.axis          (axis_s1),
		.depth         (ax_depth),
		.contact       (ax_contact),
		.flags         (ax_flags),
		.emit          (emit),
		.hit           (hit),
		.res_depth     (res_depth),
		.res_axis      (res_axis),
		.res_negative  (res_negative),
		.res_contact_x (res_contact_x),
		.res_contact_y (res_contact_y),
		.res_contact_z (res_contact_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	// emit already implies the slot is free
	always_ff @(posedge clk) begin
		if (emit) begin
			hit_q             <= hit;
			depth_q           <= res_depth;
			normal_axis_q     <= res_axis;
			normal_negative_q <= res_negative;
			contact_x_q       <= res_contact_x;
			contact_y_q       <= res_contact_y;
			contact_z_q       <= res_contact_z;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = hit_q;
	assign m_tdata  = OUT_DATA_W'({contact_z_q, contact_y_q, contact_x_q,
		normal_negative_q, normal_axis_q, depth_q});

endmodule

/* design/aoc_axis_eval.sv */
// per-axis bounds, overlap depth, normal sign and saturated overlap midpoint
module aoc_axis_eval #(
	parameter int W = 32
) (
	input  logic signed [W-1:0] a_position,
	input  logic signed [W-1:0] a_offset,
	input  logic        [W-2:0] a_half_size,
	input  logic signed [W-1:0] b_position,
	input  logic signed [W-1:0] b_offset,
	input  logic        [W-2:0] b_half_size,
	output logic        [W-1:0] depth,
	output logic signed [W-1:0] contact,
	output aoc_pkg::aoc_flags_t flags
);
	import aoc_pkg::*;

	logic signed [W:0]   ca, cb;
	logic signed [W+1:0] min_a, max_a, min_b, max_b;
	logic signed [W+1:0] lo, hi, diff, mid;
	logic signed [W+2:0] sum;
	logic                fits;

	always_comb begin
		ca = {a_position[W-1], a_position} + {a_offset[W-1], a_offset};
		cb = {b_position[W-1], b_position} + {b_offset[W-1], b_offset};
		min_a = (W+2)'(ca) - $signed({3'b000, a_half_size});
		max_a = (W+2)'(ca) + $signed({3'b000, a_half_size});
		min_b = (W+2)'(cb) - $signed({3'b000, b_half_size});
		max_b = (W+2)'(cb) + $signed({3'b000, b_half_size});
		lo = (min_a > min_b) ? min_a : min_b;
		hi = (max_a < max_b) ? max_a : max_b;
		diff = hi - lo;
		flags.miss = !(hi > lo);
		flags.neg  = !(min_a < min_b);
		// positive overlap is at most twice a half size, so it fits in W bits
		depth = flags.miss ? '0 : diff[W-1:0];
		// floor of the midpoint is an arithmetic shift of the exact sum
		sum = (W+3)'(lo) + (W+3)'(hi);
		mid = sum[W+2:1];
		fits = (mid[W+1] == mid[W]) && (mid[W] == mid[W-1]);
		if (fits) begin
			contact = mid[W-1:0];
		end else if (mid[W+1]) begin
			contact = {1'b1, {(W-1){1'b0}}};
		end else begin
			contact = {1'b0, {(W-1){1'b1}}};
		end
	end

endmodule

/* design/aoc_fold.sv */
// running best-axis state across x, y, z items and result forming on z
module aoc_fold #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  aoc_pkg::axis_t      axis,
	input  logic        [W-1:0] depth,
	input  logic signed [W-1:0] contact,
	input  aoc_pkg::aoc_flags_t flags,
	output logic                emit,
	output logic                hit,
	output logic        [W-2:0] res_depth,
	output aoc_pkg::axis_t      res_axis,
	output logic                res_negative,
	output logic signed [W-1:0] res_contact_x,
	output logic signed [W-1:0] res_contact_y,
	output logic signed [W-1:0] res_contact_z
);
	import aoc_pkg::*;

	logic [W-1:0]        best_depth_q;
	axis_t               best_axis_q;
	logic                best_negative_q;
	logic                any_miss_q;
	logic signed [W-1:0] held_contact_x_q;
	logic signed [W-1:0] held_contact_y_q;

	logic         is_x, is_yz, fold_best;
	logic         nxt_miss, nxt_negative;
	logic [W-1:0] nxt_depth;
	axis_t        nxt_axis;

	always_comb begin
		is_x      = (axis == AXIS_X);
		is_yz     = (axis == AXIS_Y) || (axis == AXIS_Z);
		fold_best = is_yz && (depth < best_depth_q);
		nxt_miss  = is_x ? flags.miss : (any_miss_q | flags.miss);
		nxt_depth = (is_x || fold_best) ? depth : best_depth_q;
		nxt_negative = (is_x || fold_best) ? flags.neg : best_negative_q;
		if (is_x) begin
			nxt_axis = AXIS_X;
		end else if (fold_best) begin
			nxt_axis = axis;
		end else begin
			nxt_axis = best_axis_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_depth_q     <= '0;
			best_axis_q      <= AXIS_X;
			best_negative_q  <= 1'b0;
			any_miss_q       <= 1'b0;
			held_contact_x_q <= '0;
			held_contact_y_q <= '0;
		end else if (take && (is_x || is_yz)) begin
			best_depth_q    <= nxt_depth;
			best_axis_q     <= nxt_axis;
			best_negative_q <= nxt_negative;
			any_miss_q      <= nxt_miss;
			if (is_x) begin
				held_contact_x_q <= contact;
			end
			if (axis == AXIS_Y) begin
				held_contact_y_q <= contact;
			end
		end
	end

	always_comb begin
		emit = take && (axis == AXIS_Z);
		hit  = !nxt_miss;
		if (hit) begin
			res_depth     = nxt_depth[W-1] ? {(W-1){1'b1}} : nxt_depth[W-2:0];
			res_axis      = nxt_axis;
			res_negative  = nxt_negative;
			res_contact_x = held_contact_x_q;
			res_contact_y = held_contact_y_q;
			res_contact_z = contact;
		end else begin
			res_depth     = '0;
			res_axis      = AXIS_X;
			res_negative  = 1'b0;
			res_contact_x = '0;
			res_contact_y = '0;
			res_contact_z = '0;
		end
	end

endmodule

/* design/aoc_checker.sv */
// port-level checks on the result channel of the box overlap block
module aoc_checker #(
	parameter int COORD_WIDTH = 32
) (
	input logic                                        clk,
	input logic                                        arst_n,
	input logic                                        m_tvalid,
	input logic                                        m_tready,
	input logic [((4 * COORD_WIDTH + 2 + 7) / 8) * 8 - 1:0] m_tdata,
	input logic [0:0]                                  m_tuser
);
	import aoc_pkg::*;

	localparam int W = COORD_WIDTH;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a miss carries all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("miss result with nonzero fields");

	// a hit has a real axis
	a_hit_axis: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[W:W-1] != AXIS_NONE)
		else $error("hit with invalid normal axis");

endmodule

bind aabb_overlap_contact aoc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_aoc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* tb/sv/tb_aabb_overlap_contact.sv */
// self-checking testbench for the box overlap contact block with its own predictor
module tb_aabb_overlap_contact;
	timeunit 1ns;
	timeprecision 1ps;

	import aoc_pkg::*;

	localparam int COORD_W     = 32;
	localparam int IN_W        = ((6 * COORD_W - 2 + 7) / 8) * 8;
	localparam int OUT_W       = ((4 * COORD_W + 2 + 7) / 8) * 8;
	localparam longint HALF_MAX  = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;

	// how many real axis items the random part sends
	localparam int RANDOM_ITEMS = 1700;
	// cycles with no transfer on either side before the run is called dead
	localparam int QUIET_LIMIT  = 1000;
	// result pipeline is two deep, give it a little more
	localparam int DRAIN_CYCLES = 10;
	// receiver hold-off that backs the block up into its input
	localparam int HOLD_CYCLES  = 150;
	localparam int HOLD_AT      = 120;

	// shapes of generated box pairs
	localparam int STYLE_NEAR    = 0;
	localparam int STYLE_TIGHT   = 1;
	localparam int STYLE_WIDE    = 2;
	localparam int STYLE_EXTREME = 3;

	typedef struct {
		axis_t              axis;
		logic signed [31:0] a_pos;
		logic signed [31:0] a_off;
		logic [30:0]        a_half;
		logic signed [31:0] b_pos;
		logic signed [31:0] b_off;
		logic [30:0]        b_half;
	} axis_item_t;

	typedef struct {
		logic               hit;
		logic [30:0]        depth;
		axis_t              normal_axis;
		logic               normal_negative;
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
		logic signed [31:0] contact_z;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	axis_t s_tuser = AXIS_X;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [0:0] m_tuser;

	aabb_overlap_contact #(
		.COORD_WIDTH(COORD_W)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		// a_position, a_offset, a_half_size, b_position, b_offset, b_half_size
		.s_tdata (s_tdata),
		// axis
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		// depth, normal_axis, normal_negative, contact_x, contact_y, contact_z
		.m_tdata (m_tdata),
		// hit
		.m_tuser (m_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// predictor: running least-penetration state across axis items
	// ---------------------------------------------------------------
	longint best_depth = 0;
	axis_t best_axis = AXIS_X;
	bit best_negative = 1'b0;
	bit any_miss = 1'b0;
	longint held_x = 0;
	longint held_y = 0;

	// results the block still owes, oldest first
	contact_t pending_contacts[$];

	function automatic void fold_axis(axis_item_t it);
		longint ctr_a, ctr_b, ha, hb, min_a, max_a, min_b, max_b, lo, hi, mid, overlap;
		bit miss, neg;
		contact_t r;
		// the spare code carries nothing and leaves the state alone
		if (it.axis == AXIS_NONE)
			return;
		// centers and bounds are exact in 64 bits, no wrap at 32
		ctr_a = longint'(it.a_pos) + longint'(it.a_off);
		ctr_b = longint'(it.b_pos) + longint'(it.b_off);
		ha = longint'(it.a_half);
		hb = longint'(it.b_half);
		min_a = ctr_a - ha;
		max_a = ctr_a + ha;
		min_b = ctr_b - hb;
		max_b = ctr_b + hb;
		lo = (min_a > min_b) ? min_a : min_b;
		hi = (max_a < max_b) ? max_a : max_b;
		// touching or apart counts as a miss, and its depth as zero
		miss = !(hi > lo);
		overlap = miss ? 0 : hi - lo;
		neg = !(min_a < min_b);
		// floor of the midpoint, then clamp into the signed coordinate range
		mid = (lo + hi) >>> 1;
		if (mid > HALF_MAX)
			mid = HALF_MAX;
		else if (mid < COORD_MIN)
			mid = COORD_MIN;

		if (it.axis == AXIS_X) begin
			// x opens a new pair and overwrites everything
			best_depth = overlap;
			best_axis = AXIS_X;
			best_negative = neg;
			any_miss = miss;
			held_x = mid;
			return;
		end
		// y and z fold in, strict less-than keeps the earlier axis on a tie
		any_miss |= miss;
		if (overlap < best_depth) begin
			best_depth = overlap;
			best_axis = it.axis;
			best_negative = neg;
		end
		if (it.axis == AXIS_Y) begin
			held_y = mid;
			return;
		end
		// every z closes a pair, repeated or not
		if (any_miss) begin
			r = '{hit: 1'b0, depth: '0, normal_axis: AXIS_X, normal_negative: 1'b0,
				contact_x: '0, contact_y: '0, contact_z: '0};
		end else begin
			r.hit = 1'b1;
			r.depth = (best_depth > HALF_MAX) ? HALF_MAX[30:0] : best_depth[30:0];
			r.normal_axis = best_axis;
			r.normal_negative = best_negative;
			r.contact_x = held_x[31:0];
			r.contact_y = held_y[31:0];
			r.contact_z = mid[31:0];
		end
		pending_contacts.push_back(r);
	endfunction

	// ---------------------------------------------------------------
	// stimulus shaping
	// ---------------------------------------------------------------
	axis_item_t axis_backlog[$];

	function automatic axis_item_t box_axis(axis_t ax, longint apos, longint aoff,
		longint ahalf, longint bpos, longint boff, longint bhalf);
		axis_item_t it;
		it.axis = ax;
		it.a_pos = apos[31:0];
		it.a_off = aoff[31:0];
		it.a_half = ahalf[30:0];
		it.b_pos = bpos[31:0];
		it.b_off = boff[31:0];
		it.b_half = bhalf[30:0];
		return it;
	endfunction

	// pick a corner value, or at times a random one, for a signed coordinate
	function automatic logic [31:0] corner_coord();
		case ($urandom_range(0, 4))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] corner_half();
		case ($urandom_range(0, 3))
			0: return 31'h7fff_ffff;
			1: return 31'd0;
			2: return 31'd1;
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic axis_item_t make_axis(axis_t ax, int style);
		axis_item_t it;
		logic [31:0] base;
		it.axis = ax;
		case (style)
			STYLE_NEAR: begin
				// B sits close to A so that most axes overlap, anywhere in range
				base = $urandom;
				it.a_pos = base;
				it.a_off = $urandom_range(0, 'h20000) - 'h10000;
				it.a_half = 31'($urandom_range(0, 'h60000));
				it.b_pos = base + $urandom_range(0, 'h40000) - 'h20000;
				it.b_off = $urandom_range(0, 'h20000) - 'h10000;
				it.b_half = 31'($urandom_range(0, 'h60000));
			end
			STYLE_TIGHT: begin
				// tiny integers: exact ties, touching faces and zero sizes
				it.a_pos = $urandom_range(0, 8) - 4;
				it.a_off = $urandom_range(0, 4) - 2;
				it.a_half = 31'($urandom_range(0, 4));
				it.b_pos = $urandom_range(0, 8) - 4;
				it.b_off = $urandom_range(0, 4) - 2;
				it.b_half = 31'($urandom_range(0, 4));
			end
			STYLE_WIDE: begin
				it.a_pos = $urandom;
				it.a_off = $urandom;
				it.a_half = 31'($urandom);
				it.b_pos = $urandom;
				it.b_off = $urandom;
				it.b_half = 31'($urandom);
			end
			default: begin
				// corners drive the 34-bit bounds and both saturations
				it.a_pos = corner_coord();
				it.a_off = corner_coord();
				it.a_half = corner_half();
				it.b_pos = corner_coord();
				it.b_off = corner_coord();
				it.b_half = corner_half();
			end
		endcase
		return it;
	endfunction

	function automatic int pick_style();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return STYLE_NEAR;
		if (roll < 75)
			return STYLE_TIGHT;
		if (roll < 90)
			return STYLE_WIDE;
		return STYLE_EXTREME;
	endfunction

	// ---------------------------------------------------------------
	// mismatch reporting
	// ---------------------------------------------------------------
	int n_errors = 0;

	task automatic report_error(string msg);
		// keep the log short when the block is badly broken
		if (n_errors < 50)
			$display("[%0t] mismatch: %s", $realtime, msg);
		n_errors++;
	endtask

	task automatic check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
		if (got_v !== want_v)
			report_error($sformatf("%s got %h want %h", name, got_v, want_v));
	endtask

	// ---------------------------------------------------------------
	// driver: offers queued axis items, predicts each one on its transfer
	// ---------------------------------------------------------------
	axis_item_t cur_item;
	int n_sent = 0;
	int n_results = 0;
	logic sink_hold = 1'b0;

	always @(posedge clk) begin : feed
		bit offer;
		bit calm;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				fold_axis(cur_item);
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				// a stretch with no gaps, and no gaps while the receiver holds off
				calm = (n_sent >= 700 && n_sent < 1000) || sink_hold;
				offer = axis_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 31);
				if (offer) begin
					cur_item = axis_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, cur_item.b_half, cur_item.b_off, cur_item.b_pos,
						cur_item.a_half, cur_item.a_off, cur_item.a_pos};
					s_tuser <= cur_item.axis;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: checks each result transfer against the oldest prediction
	// ---------------------------------------------------------------
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk) begin : sink
		contact_t got;
		contact_t want;
		bit calm;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				got.hit = m_tuser[0];
				got.depth = m_tdata[30:0];
				got.normal_axis = axis_t'(m_tdata[32:31]);
				got.normal_negative = m_tdata[33];
				got.contact_x = m_tdata[65:34];
				got.contact_y = m_tdata[97:66];
				got.contact_z = m_tdata[129:98];
				if (pending_contacts.size() == 0) begin
					report_error("result transfer with no prediction waiting");
				end else begin
					want = pending_contacts.pop_front();
					check_field("hit", 32'(got.hit), 32'(want.hit));
					check_field("depth", 32'(got.depth), 32'(want.depth));
					check_field("normal_axis", 32'(got.normal_axis), 32'(want.normal_axis));
					check_field("normal_negative", 32'(got.normal_negative),
						32'(want.normal_negative));
					check_field("contact_x", got.contact_x, want.contact_x);
					check_field("contact_y", got.contact_y, want.contact_y);
					check_field("contact_z", got.contact_z, want.contact_z);
				end
			end
			// one long hold-off so the pipeline fills and s_tready drops
			if (hold_left != 0)
				hold_left--;
			else if (!hold_done && n_results >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			sink_hold <= (hold_left != 0);
			calm = n_results >= 200 && n_results < 260;
			m_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 31);
		end
	end

	// ---------------------------------------------------------------
	// watchdog: too long without any transfer means the block is stuck
	// ---------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------
	initial begin : run
		int n_real;
		int ax;
		longint hmax;
		hmax = HALF_MAX;

		// y and z straight after reset fold into the cleared state: hit at depth zero on x
		axis_backlog.push_back(box_axis(AXIS_Y, 0, 0, 4, 2, 0, 4));
		axis_backlog.push_back(box_axis(AXIS_Z, 0, 0, 4, 2, 0, 4));
		// the spare axis code is ignored
		axis_backlog.push_back(box_axis(AXIS_NONE, -1, -1, hmax, -1, -1, hmax));
		// equal depth on every axis picks x
		axis_backlog.push_back(box_axis(AXIS_X, 0, 0, 10, 5, 0, 10));
		axis_backlog.push_back(box_axis(AXIS_Y, 0, 0, 10, 5, 0, 10));
		axis_backlog.push_back(box_axis(AXIS_Z, 0, 0, 10, 5, 0, 10));
		// y and z tie below x: y wins, z has the normal flipped
		axis_backlog.push_back(box_axis(AXIS_X, 0, 0, 10, 5, 0, 10));
		axis_backlog.push_back(box_axis(AXIS_Y, 0, 0, 10, 10, 0, 10));
		axis_backlog.push_back(box_axis(AXIS_Z, 10, 0, 10, 0, 0, 10));
		// faces touching on x is a miss, whole result zero
		axis_backlog.push_back(box_axis(AXIS_X, 0, 0, 5, 10, 0, 5));
		axis_backlog.push_back(box_axis(AXIS_Y, 0, 0, 5, 1, 0, 5));
		axis_backlog.push_back(box_axis(AXIS_Z, 0, 0, 5, 1, 0, 5));
		// largest boxes: depth saturates, contact clamps high and low
		axis_backlog.push_back(box_axis(AXIS_X, hmax, hmax, hmax, hmax, hmax, hmax));
		axis_backlog.push_back(box_axis(AXIS_Y, COORD_MIN, COORD_MIN, hmax,
			COORD_MIN, COORD_MIN, hmax));
		axis_backlog.push_back(box_axis(AXIS_Z, 0, 0, hmax, 0, 0, hmax));
		// points at opposite corners of the range
		axis_backlog.push_back(box_axis(AXIS_X, COORD_MIN, COORD_MIN, 0, hmax, hmax, 0));
		axis_backlog.push_back(make_axis(AXIS_Y, STYLE_WIDE));
		axis_backlog.push_back(make_axis(AXIS_Z, STYLE_WIDE));
		// z sent twice: each one closes a pair
		axis_backlog.push_back(box_axis(AXIS_X, 0, 0, 3, 1, 0, 3));
		axis_backlog.push_back(box_axis(AXIS_Y, 0, 0, 3, 2, 0, 3));
		axis_backlog.push_back(box_axis(AXIS_Z, 0, 0, 3, -1, 0, 2));
		axis_backlog.push_back(box_axis(AXIS_Z, 0, 1, 3, 0, 0, 1));
		// y skipped
		axis_backlog.push_back(box_axis(AXIS_X, -7, 2, 6, -3, 0, 4));
		axis_backlog.push_back(box_axis(AXIS_Z, 4, -1, 2, 3, 1, 2));

		// mostly whole x, y, z pairs; the rest loose axes and spare codes
		n_real = 0;
		while (n_real < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 80) begin
				for (int i = 0; i < 3; i++)
					axis_backlog.push_back(make_axis(axis_t'(i), pick_style()));
				n_real += 3;
			end else begin
				ax = $urandom_range(0, 3);
				axis_backlog.push_back(make_axis(axis_t'(ax), pick_style()));
				if (axis_t'(ax) != AXIS_NONE)
					n_real++;
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (axis_backlog.size() != 0 || s_tvalid)
			@(posedge clk);
		while (pending_contacts.size() != 0)
			@(posedge clk);
		// catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
design/aoc_pkg.sv
design/aoc_axis_eval.sv
design/aoc_fold.sv
design/aabb_overlap_contact.sv
design/aoc_checker.sv
tb/sv/tb_aabb_overlap_contact.sv
